>>> hdl/ffsa_pkg.sv
// ----------------------------------------------------------------------------
// ffsa_pkg
// Shared types and constants of the first-fit segment allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ffsa_pkg;

    localparam int HEADER_BYTES = 32;
    localparam int MAX_SEGMENTS = 64;
    localparam int REGION_BYTES = 1048576;
    localparam int SPLIT_SLACK  = 8;

    localparam int IDX_W  = $clog2(MAX_SEGMENTS);
    localparam int CNT_W  = $clog2(MAX_SEGMENTS + 1);
    localparam int SIZE_W = 21;
    localparam int ADDR_W = 32;
    localparam int WIDE_W = SIZE_W + 2;

    localparam logic [SIZE_W-1:0] HDR  = SIZE_W'(HEADER_BYTES);
    localparam logic [SIZE_W-1:0] RLIM = SIZE_W'(REGION_BYTES);
    localparam logic [CNT_W-1:0]  MAXC = CNT_W'(MAX_SEGMENTS);

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_NULL    = 3'd1,
        ST_DOUBLE  = 3'd2,
        ST_NOSPACE = 3'd3,
        ST_FULL    = 3'd4
    } t_status;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic CFG_BASE = 1'b0;
    localparam logic CFG_SIZE = 1'b1;

    typedef struct packed {
        logic              is_free;
        logic [SIZE_W-1:0] offset;
        logic [SIZE_W-1:0] size;
    } t_seg;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        t_seg             wdata;
        logic [IDX_W-1:0] raddr;
    } t_ram_req;

endpackage

`default_nettype wire

>>> hdl/first_fit_segment_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_segment_allocator
// First-fit allocator over an address-ordered segment table with split and
// coalesce; each command yields one result beat with the byte totals.
// ----------------------------------------------------------------------------
// A command is taken when i_start is high and o_busy is low; its single
// result beat appears later for one cycle with o_valid and cannot be stalled.
// The segment table sits in one memory with one read and one write per cycle,
// and each table entry visited passes through a read state and then a check
// state (read, then check); a split or merge then shifts the later entries up
// or down, one entry at a time.
`default_nettype none

module first_fit_segment_allocator (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        i_start,
    output logic             o_busy,
    input  wire logic        i_opcode,
    input  wire logic [20:0] i_request_size,
    input  wire logic [31:0] i_address,
    output logic             o_valid,
    output logic [31:0]      o_alloc_address,
    output logic [2:0]       o_status,
    output logic [20:0]      o_used_bytes,
    output logic [20:0]      o_free_bytes
);
    import ffsa_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN_RD, S_SCAN_CHK, S_UP_RD, S_UP_WR, S_NEXT_RD, S_NEXT_CHK,
        S_DN_RD, S_DN_WR, S_PREV_RD, S_PREV_CHK, S_DONE
    } t_state;

    t_state             r_state;
    logic [ADDR_W-1:0]  r_base;
    logic [SIZE_W-1:0]  r_msize;
    logic               r_op;
    logic [SIZE_W-1:0]  r_req;
    logic [ADDR_W-1:0]  r_addr_in;
    logic [CNT_W-1:0]   r_count;
    logic [SIZE_W-1:0]  r_bump;
    logic [SIZE_W-1:0]  r_used;
    logic [SIZE_W-1:0]  r_free;
    logic [CNT_W-1:0]   r_i;
    logic [CNT_W-1:0]   r_j;
    logic               r_phase;
    t_seg               r_s;
    t_seg               r_rest;
    logic [ADDR_W-1:0]  r_grant;
    t_status            r_status;
    logic               r_valid;

    t_ram_req           ram_req;
    t_seg               rd;

    logic [WIDE_W-1:0]  w_need_split;
    logic [WIDE_W-1:0]  w_end_s;
    logic [WIDE_W-1:0]  w_end_p;
    logic [WIDE_W-1:0]  w_bump_end;
    logic [SIZE_W-1:0]  w_limit;
    logic               w_split;

    ffsa_seg_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (ram_req),
        .o_rdata (rd)
    );

    assign w_need_split = WIDE_W'(r_req) + WIDE_W'(HEADER_BYTES + SPLIT_SLACK);
    assign w_split      = (WIDE_W'(rd.size) >= w_need_split) && (r_count < MAXC);
    assign w_end_s      = WIDE_W'(r_s.offset) + WIDE_W'(r_s.size) + WIDE_W'(HDR);
    assign w_end_p      = WIDE_W'(rd.offset) + WIDE_W'(rd.size) + WIDE_W'(HDR);
    assign w_bump_end   = WIDE_W'(r_bump) + WIDE_W'(HDR) + WIDE_W'(r_req);
    assign w_limit      = (r_msize > RLIM) ? RLIM : r_msize;

    always_comb begin
        ram_req       = '0;
        ram_req.raddr = r_i[IDX_W-1:0];
        case (r_state)
            S_SCAN_RD: begin
                ram_req.raddr = r_i[IDX_W-1:0];
            end
            S_SCAN_CHK: begin
                ram_req.waddr = r_i[IDX_W-1:0];
                if (r_op == OP_ALLOC) begin
                    if (rd.is_free && rd.size >= r_req) begin
                        ram_req.we            = 1'b1;
                        ram_req.wdata.is_free = 1'b0;
                        ram_req.wdata.offset  = rd.offset;
                        ram_req.wdata.size    = w_split ? r_req : rd.size;
                    end
                end else if ((r_base + ADDR_W'(rd.offset)) == r_addr_in && !rd.is_free) begin
                    ram_req.we            = 1'b1;
                    ram_req.wdata         = rd;
                    ram_req.wdata.is_free = 1'b1;
                end
                if (r_op == OP_ALLOC && r_i == r_count) begin
                    ram_req.we            = 1'b1;
                    ram_req.wdata.is_free = 1'b0;
                    ram_req.wdata.offset  = r_bump + HDR;
                    ram_req.wdata.size    = r_req;
                end
            end
            S_UP_RD: begin
                ram_req.raddr = IDX_W'(r_j - 1'b1);
                if (r_j == r_i + 1'b1) begin
                    ram_req.we    = 1'b1;
                    ram_req.waddr = r_j[IDX_W-1:0];
                    ram_req.wdata = r_rest;
                end
            end
            S_UP_WR: begin
                ram_req.we    = 1'b1;
                ram_req.waddr = r_j[IDX_W-1:0];
                ram_req.wdata = rd;
            end
            S_NEXT_RD: begin
                ram_req.raddr = IDX_W'(r_i + 1'b1);
            end
            S_NEXT_CHK: begin
                ram_req.waddr        = r_i[IDX_W-1:0];
                ram_req.wdata        = r_s;
                ram_req.wdata.size   = r_s.size + HDR + rd.size;
                ram_req.we           = rd.is_free && (w_end_s == WIDE_W'(rd.offset));
            end
            S_DN_RD: begin
                ram_req.raddr = r_j[IDX_W-1:0];
            end
            S_DN_WR: begin
                ram_req.we    = 1'b1;
                ram_req.waddr = IDX_W'(r_j - 1'b1);
                ram_req.wdata = rd;
            end
            S_PREV_RD: begin
                ram_req.raddr = IDX_W'(r_i - 1'b1);
            end
            S_PREV_CHK: begin
                ram_req.waddr      = IDX_W'(r_i - 1'b1);
                ram_req.wdata      = rd;
                ram_req.wdata.size = rd.size + HDR + r_s.size;
                ram_req.we         = rd.is_free && (w_end_p == WIDE_W'(r_s.offset));
            end
            default: begin
                ram_req.we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_base   <= '0;
            r_msize  <= RLIM;
            r_count  <= '0;
            r_bump   <= '0;
            r_used   <= '0;
            r_free   <= '0;
            r_valid  <= 1'b0;
            r_status <= ST_OK;
            r_grant  <= '0;
        end else begin
            r_valid <= 1'b0;
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_BASE) begin
                    r_base <= i_cfg_data;
                end else begin
                    r_msize <= i_cfg_data[SIZE_W-1:0];
                end
            end
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_op      <= i_opcode;
                        r_req     <= i_request_size;
                        r_addr_in <= i_address;
                        r_i       <= '0;
                        r_grant   <= '0;
                        r_status  <= ST_OK;
                        r_phase   <= 1'b0;
                        if ((i_opcode == OP_ALLOC && i_request_size == '0) ||
                            (i_opcode == OP_FREE && i_address == '0)) begin
                            r_status <= ST_NULL;
                            r_state  <= S_DONE;
                        end else begin
                            r_state <= S_SCAN_RD;
                        end
                    end
                end
                S_SCAN_RD: begin
                    if (r_i == r_count) begin
                        r_state <= S_DONE;
                        if (r_op == OP_FREE) begin
                            r_status <= ST_NULL;
                        end else if (w_bump_end > WIDE_W'(w_limit)) begin
                            r_status <= ST_NOSPACE;
                        end else if (r_count >= MAXC) begin
                            r_status <= ST_FULL;
                        end else begin
                            r_i     <= r_count;
                            r_state <= S_SCAN_CHK;
                        end
                    end else begin
                        r_state <= S_SCAN_CHK;
                    end
                end
                S_SCAN_CHK: begin
                    r_state <= S_SCAN_RD;
                    r_i     <= r_i + 1'b1;
                    if (r_op == OP_ALLOC && r_i == r_count) begin
                        r_count <= r_count + 1'b1;
                        r_bump  <= SIZE_W'(w_bump_end);
                        r_used  <= r_used + r_req;
                        r_grant <= r_base + ADDR_W'(r_bump) + ADDR_W'(HDR);
                        r_state <= S_DONE;
                    end else if (r_op == OP_ALLOC) begin
                        if (rd.is_free && rd.size >= r_req) begin
                            r_i     <= r_i;
                            r_grant <= r_base + ADDR_W'(rd.offset);
                            if (w_split) begin
                                r_used         <= r_used + r_req;
                                r_free         <= r_free - r_req - HDR;
                                r_rest.is_free <= 1'b1;
                                r_rest.offset  <= rd.offset + r_req + HDR;
                                r_rest.size    <= rd.size - r_req - HDR;
                                r_j            <= r_count;
                                r_state        <= S_UP_RD;
                            end else begin
                                r_used  <= r_used + rd.size;
                                r_free  <= r_free - rd.size;
                                r_state <= S_DONE;
                            end
                        end
                    end else if ((r_base + ADDR_W'(rd.offset)) == r_addr_in) begin
                        r_i <= r_i;
                        if (rd.is_free) begin
                            r_status <= ST_DOUBLE;
                            r_state  <= S_DONE;
                        end else begin
                            r_s         <= rd;
                            r_s.is_free <= 1'b1;
                            r_used      <= r_used - rd.size;
                            r_free      <= r_free + rd.size;
                            r_state     <= S_NEXT_RD;
                        end
                    end
                end
                S_UP_RD: begin
                    if (r_j == r_i + 1'b1) begin
                        r_count <= r_count + 1'b1;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_UP_WR;
                    end
                end
                S_UP_WR: begin
                    r_j     <= r_j - 1'b1;
                    r_state <= S_UP_RD;
                end
                S_NEXT_RD: begin
                    r_state <= (r_i + 1'b1 < r_count) ? S_NEXT_CHK : S_PREV_RD;
                end
                S_NEXT_CHK: begin
                    if (rd.is_free && (w_end_s == WIDE_W'(rd.offset))) begin
                        r_s.size <= r_s.size + HDR + rd.size;
                        r_free   <= r_free + HDR;
                        r_j      <= r_i + 2'd2;
                        r_state  <= S_DN_RD;
                    end else begin
                        r_state <= S_PREV_RD;
                    end
                end
                S_DN_RD: begin
                    if (r_j == r_count) begin
                        r_count <= r_count - 1'b1;
                        r_phase <= 1'b1;
                        r_state <= r_phase ? S_DONE : S_PREV_RD;
                    end else begin
                        r_state <= S_DN_WR;
                    end
                end
                S_DN_WR: begin
                    r_j     <= r_j + 1'b1;
                    r_state <= S_DN_RD;
                end
                S_PREV_RD: begin
                    r_state <= (r_i != '0) ? S_PREV_CHK : S_DONE;
                end
                S_PREV_CHK: begin
                    if (rd.is_free && (w_end_p == WIDE_W'(r_s.offset))) begin
                        r_free  <= r_free + HDR;
                        r_j     <= r_i + 1'b1;
                        r_phase <= 1'b1;
                        r_state <= S_DN_RD;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    r_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_busy          = (r_state != S_IDLE);
    assign o_valid         = r_valid;
    assign o_alloc_address = r_grant;
    assign o_status        = r_status;
    assign o_used_bytes    = r_used;
    assign o_free_bytes    = r_free;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= MAXC) else $error("Segment count exceeds table depth.");

    a_valid_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state == S_DONE)) else $error("Result beat without completion.");

    a_fail_no_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |-> (o_alloc_address == '0))
        else $error("Failed command granted an address.");

endmodule

`default_nettype wire

>>> hdl/ffsa_seg_ram.sv
// ----------------------------------------------------------------------------
// ffsa_seg_ram
// Segment table memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ffsa_seg_ram (
    input  wire logic              i_clk,
    input  wire ffsa_pkg::t_ram_req i_req,
    output ffsa_pkg::t_seg         o_rdata
);
    import ffsa_pkg::*;

    t_seg r_mem [MAX_SEGMENTS];
    t_seg r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> verif/first_fit_segment_allocator_test.sv
// ----------------------------------------------------------------------------
// first_fit_segment_allocator_test
// Self-checking testbench for the first-fit segment allocator. A behavioural
// model of the segment table predicts every result beat; directed tests cover
// the corner cases, random traffic with varying sender gaps covers the rest.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_segment_allocator_test;
    import ffsa_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int DRAIN_WAIT  = 4 * MAX_SEGMENTS + 16;

    typedef struct {
        logic [31:0] offset;
        logic [31:0] size;
        logic        is_free;
    } seg_rec_t;

    typedef struct {
        logic [31:0] addr;
        t_status     status;
        logic [20:0] used;
        logic [20:0] unused;
    } alloc_result_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [31:0] i_cfg_data;
    logic        i_start;
    logic        o_busy;
    logic        i_opcode;
    logic [20:0] i_request_size;
    logic [31:0] i_address;
    logic        o_valid;
    logic [31:0] o_alloc_address;
    logic [2:0]  o_status;
    logic [20:0] o_used_bytes;
    logic [20:0] o_free_bytes;

    first_fit_segment_allocator dut (.*);

    seg_rec_t      seg_tab [MAX_SEGMENTS];
    int unsigned   seg_count;
    logic [31:0]   bump_ptr;
    logic [31:0]   base_reg;
    logic [31:0]   size_reg;
    alloc_result_t expected_q[$];
    logic [31:0]   live_addrs[$];
    logic [31:0]   freed_addrs[$];
    int            sender_idle_pct;
    int            mismatches;
    int unsigned   cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("first_fit_segment_allocator verification failed");
            $finish;
        end
    end

    task automatic note_mismatch(string what, logic [31:0] exp_v, logic [31:0] act_v);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch on %s: expected %0h, got %0h", what, exp_v, act_v);
    endtask

    // Each result beat is compared with the oldest prediction.
    always @(posedge i_clk) begin
        alloc_result_t e;
        if (i_rst_n && o_valid) begin
            if (expected_q.size() == 0) begin
                note_mismatch("unexpected beat", 32'h0, o_alloc_address);
            end else begin
                e = expected_q.pop_front();
                if (o_alloc_address !== e.addr)
                    note_mismatch("alloc_address", e.addr, o_alloc_address);
                if (o_status !== e.status)
                    note_mismatch("status", 32'(e.status), 32'(o_status));
                if (o_used_bytes !== e.used)
                    note_mismatch("used_bytes", 32'(e.used), 32'(o_used_bytes));
                if (o_free_bytes !== e.unused)
                    note_mismatch("free_bytes", 32'(e.unused), 32'(o_free_bytes));
            end
        end
    end

    function automatic void drop_segment(int unsigned idx);
        for (int unsigned j = idx; j + 1 < seg_count; j++)
            seg_tab[j] = seg_tab[j + 1];
        seg_count--;
    endfunction

    function automatic t_status model_alloc(logic [31:0] req, output logic [31:0] addr);
        logic [31:0] limit;
        addr = 32'h0;
        if (req == 0)
            return ST_NULL;
        for (int unsigned i = 0; i < seg_count; i++) begin
            if (seg_tab[i].is_free && seg_tab[i].size >= req) begin
                seg_tab[i].is_free = 1'b0;
                if (seg_tab[i].size >= req + HEADER_BYTES + SPLIT_SLACK
                        && seg_count < MAX_SEGMENTS) begin
                    for (int unsigned j = seg_count; j > i + 1; j--)
                        seg_tab[j] = seg_tab[j - 1];
                    seg_tab[i + 1].offset  = seg_tab[i].offset + req + HEADER_BYTES;
                    seg_tab[i + 1].size    = seg_tab[i].size - req - HEADER_BYTES;
                    seg_tab[i + 1].is_free = 1'b1;
                    seg_tab[i].size = req;
                    seg_count++;
                end
                addr = base_reg + seg_tab[i].offset;
                return ST_OK;
            end
        end
        limit = (size_reg > REGION_BYTES) ? 32'(REGION_BYTES) : size_reg;
        if (bump_ptr + HEADER_BYTES + req > limit)
            return ST_NOSPACE;
        if (seg_count >= MAX_SEGMENTS)
            return ST_FULL;
        seg_tab[seg_count].offset  = bump_ptr + HEADER_BYTES;
        seg_tab[seg_count].size    = req;
        seg_tab[seg_count].is_free = 1'b0;
        seg_count++;
        bump_ptr = bump_ptr + HEADER_BYTES + req;
        addr = base_reg + bump_ptr - req;
        return ST_OK;
    endfunction

    function automatic t_status model_release(logic [31:0] a);
        if (a == 0)
            return ST_NULL;
        for (int unsigned i = 0; i < seg_count; i++) begin
            if (base_reg + seg_tab[i].offset == a) begin
                if (seg_tab[i].is_free)
                    return ST_DOUBLE;
                seg_tab[i].is_free = 1'b1;
                if (i + 1 < seg_count && seg_tab[i + 1].is_free
                        && seg_tab[i].offset + seg_tab[i].size + HEADER_BYTES
                           == seg_tab[i + 1].offset) begin
                    seg_tab[i].size += HEADER_BYTES + seg_tab[i + 1].size;
                    drop_segment(i + 1);
                end
                if (i > 0 && seg_tab[i - 1].is_free
                        && seg_tab[i - 1].offset + seg_tab[i - 1].size + HEADER_BYTES
                           == seg_tab[i].offset) begin
                    seg_tab[i - 1].size += HEADER_BYTES + seg_tab[i].size;
                    drop_segment(i);
                end
                return ST_OK;
            end
        end
        return ST_NULL;
    endfunction

    function automatic alloc_result_t predict_result(logic op, logic [20:0] req,
                                                     logic [31:0] a);
        alloc_result_t r;
        logic [31:0]   u, f;
        if (op == OP_ALLOC)
            r.status = model_alloc(32'(req), r.addr);
        else begin
            r.status = model_release(a);
            r.addr = 32'h0;
        end
        u = 0;
        f = 0;
        for (int unsigned i = 0; i < seg_count; i++) begin
            if (seg_tab[i].is_free)
                f += seg_tab[i].size;
            else
                u += seg_tab[i].size;
        end
        r.used   = u[20:0];
        r.unused = f[20:0];
        return r;
    endfunction

    // Sends one command beat; returns once it has been accepted, start left high.
    task automatic send_cmd(logic op, logic [20:0] req, logic [31:0] a);
        alloc_result_t r;
        if ($urandom_range(99) < sender_idle_pct) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_start        <= 1'b1;
        i_opcode       <= op;
        i_request_size <= req;
        i_address      <= a;
        do @(posedge i_clk); while (o_busy);
        r = predict_result(op, req, a);
        expected_q.push_back(r);
        if (op == OP_ALLOC && r.status == ST_OK)
            live_addrs.push_back(r.addr);
    endtask

    task automatic alloc_bytes(logic [20:0] req);
        send_cmd(OP_ALLOC, req, $urandom);
    endtask

    task automatic release_addr(logic [31:0] a);
        send_cmd(OP_FREE, 21'($urandom), a);
    endtask

    task automatic drain;
        i_start <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_cfg(logic idx, logic [31:0] value);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_BASE)
            base_reg = value;
        else
            size_reg = value & 32'h1F_FFFF;
    endtask

    task automatic release_live(int unsigned pick);
        logic [31:0] a;
        a = live_addrs[pick];
        live_addrs.delete(pick);
        freed_addrs.push_back(a);
        release_addr(a);
    endtask

    task automatic test_directed;
        alloc_bytes(21'd0);
        alloc_bytes(21'd1);
        alloc_bytes(21'd100);
        alloc_bytes(21'd64);
        alloc_bytes(21'd200);
        alloc_bytes(21'h1F_FFFF);
        alloc_bytes(21'd1048576);
        release_addr(32'h0);
        release_addr(32'hFFFF_FFFF);
        release_live(1);
        release_addr(freed_addrs[$]);
        release_live(1);
        release_live(1);
        alloc_bytes(21'd16);
        alloc_bytes(21'd300);
        alloc_bytes(21'd8);
        release_live(0);
        drain();
    endtask

    task automatic test_table_full;
        logic [31:0] big;
        alloc_bytes(21'd400);
        big = live_addrs[$];
        live_addrs.delete(live_addrs.size() - 1);
        while (seg_count < MAX_SEGMENTS)
            alloc_bytes(21'd8);
        alloc_bytes(21'd8);
        release_addr(big);
        alloc_bytes(21'd16);
        while (live_addrs.size() != 0)
            release_live(live_addrs.size() - 1);
        drain();
    endtask

    task automatic test_registers;
        write_cfg(CFG_BASE, 32'hFFFF_FFE0);
        alloc_bytes(21'd24);
        release_addr(32'h0);
        alloc_bytes(21'd24);
        write_cfg(CFG_SIZE, 32'h0);
        alloc_bytes(21'd500);
        write_cfg(CFG_SIZE, 32'h001F_FFFF);
        alloc_bytes(21'd500);
        write_cfg(CFG_BASE, 32'hFFFF_FFFF);
        alloc_bytes(21'd40);
        write_cfg(CFG_BASE, 32'h0);
        write_cfg(CFG_SIZE, 32'd1048576);
        live_addrs.delete();
        drain();
    endtask

    task automatic test_random(int items, int idle_pct);
        int unsigned r;
        sender_idle_pct = idle_pct;
        for (int n = 0; n < items; n++) begin
            r = $urandom_range(99);
            if (r < 45 || (r < 80 && live_addrs.size() == 0)) begin
                r = $urandom_range(99);
                if (r < 80)
                    alloc_bytes(21'($urandom_range(1, 128)));
                else if (r < 95)
                    alloc_bytes(21'($urandom_range(129, 4096)));
                else
                    alloc_bytes(21'($urandom_range(0, 21'h1F_FFFF)));
            end else if (r < 80) begin
                release_live($urandom_range(0, live_addrs.size() - 1));
            end else if (r < 88 && freed_addrs.size() != 0) begin
                release_addr(freed_addrs[$urandom_range(0, freed_addrs.size() - 1)]);
            end else if (r < 94) begin
                release_addr($urandom);
            end else if (r < 97) begin
                release_addr(32'h0);
            end else begin
                alloc_bytes(21'd0);
            end
        end
        drain();
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = CFG_BASE;
        i_cfg_data      = 32'h0;
        i_start         = 1'b0;
        i_opcode        = OP_ALLOC;
        i_request_size  = 21'h0;
        i_address       = 32'h0;
        seg_count       = 0;
        bump_ptr        = 32'h0;
        base_reg        = 32'h0;
        size_reg        = 32'd1048576;
        sender_idle_pct = 0;
        mismatches      = 0;
        cycles          = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        sender_idle_pct = 28;
        test_directed();
        test_table_full();
        test_registers();
        test_random(135, 28);
        write_cfg(CFG_BASE, 32'h0012_3400);
        test_random(135, 48);
        write_cfg(CFG_SIZE, 32'd600000);
        write_cfg(CFG_BASE, 32'h8000_0000);
        test_random(135, 0);

        drain();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatches == 0 && expected_q.size() == 0)
            $display("first_fit_segment_allocator verification clean");
        else
            $display("first_fit_segment_allocator verification failed");
        $finish;
    end

endmodule

`default_nettype wire
